// ===== rtl/core/wcsr_pkg.sv =====
package wcsr_pkg;

  localparam int CSR_IDX_W = 12;
  localparam int RECIP_SHIFT = 24;
  localparam logic [CSR_IDX_W-1:0] RPC_CSR = 12'h80c;
  localparam logic [2:0] CFG_ACTIVE_THREADS = 3'd0;
  localparam logic [6:0] ACTIVE_THREADS_RESET = 7'd32;

  typedef enum logic [3:0] {
    OP_RW      = 4'd0,
    OP_RS      = 4'd1,
    OP_RC      = 4'd2,
    OP_RWI     = 4'd3,
    OP_RSI     = 4'd4,
    OP_RCI     = 4'd5,
    OP_VRS     = 4'd6,
    OP_VSETVLI = 4'd7,
    OP_SETRPC  = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SMOD,
    ST_SOLE,
    ST_VMOD,
    ST_VBASE,
    ST_VREAD,
    ST_VLANE
  } state_t;

endpackage

// ===== rtl/core/wcsr_ram.sv =====
module wcsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/warp_csr_exec_unit.sv =====
// Per-warp CSR execution unit. After reset the block clears both CSR stores,
// one entry per cycle, up to the larger of the depths WARPS*2^CSR_ADDR_BITS
// and WARPS*VECTOR_CSR_ENTRIES*THREADS (32768 at the defaults), and takes
// no item meanwhile. Scalar read-write, set and clear read the scalar store
// when the item is accepted, then write it back and load the result once
// the output is free. VSETVLI and SETRPC load their result from ST_SOLE.
// Vector set divides the CSR address by VECTOR_CSR_ENTRIES with a reciprocal
// multiply, forms the base address and issues the first read, then goes one
// lane per cycle through the vector store while the output is not stalled,
// with the next lane read overlapping the current write-back. Items with
// write-back clear, an unknown operation or a warp out of range are dropped
// and give no result. A stalled output stalls the block.
module warp_csr_exec_unit #(
  parameter int WARPS = 8,
  parameter int THREADS = 32,
  parameter int CSR_ADDR_BITS = 12,
  parameter int VECTOR_CSR_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic [2:0]  warp_slot,
  input  logic [11:0] csr_index,
  input  logic [31:0] source_one,
  input  logic [31:0] source_two,
  input  logic        writes_back,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_warp,
  output logic [5:0]  lane_index,
  output logic [31:0] read_value,
  output logic        is_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import wcsr_pkg::*;

  localparam int SDEPTH = WARPS * (2 ** CSR_ADDR_BITS);
  localparam int VDEPTH = WARPS * VECTOR_CSR_ENTRIES * THREADS;
  localparam int CDEPTH = SDEPTH > VDEPTH ? SDEPTH : VDEPTH;
  localparam int WARP_BITS = WARPS > 1 ? $clog2(WARPS) : 1;
  localparam int SADDR_BITS = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
  localparam int VADDR_BITS = VDEPTH > 1 ? $clog2(VDEPTH) : 1;
  localparam int CLR_BITS = CDEPTH > 1 ? $clog2(CDEPTH) : 1;
  localparam int LANE_BITS = THREADS > 1 ? $clog2(THREADS) : 1;
  localparam int ENTRY_SPAN = VECTOR_CSR_ENTRIES * THREADS;
  localparam int PROD_W = CSR_IDX_W + RECIP_SHIFT + 1;
  localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'(
      ((64'd1 << RECIP_SHIFT) + 64'(VECTOR_CSR_ENTRIES) - 64'd1) / 64'(VECTOR_CSR_ENTRIES));

  state_t state, state_next;
  logic [CLR_BITS-1:0] clr_cnt, clr_cnt_next;
  logic [LANE_BITS-1:0] lane, lane_next;
  logic [LANE_BITS-1:0] lane_inc;
  logic [6:0] active_threads;

  logic in_accept, item_go, warp_ok, out_free, out_load;
  logic [31:0] out_value;
  logic [LANE_BITS-1:0] out_lane;
  logic out_last;

  op_t op_in, op_q;
  logic [2:0] warp_q;
  logic [31:0] s1_q;
  logic [31:0] res_q;
  logic [SADDR_BITS-1:0] saddr_in, saddr_q, rpc_addr;
  logic [CSR_IDX_W-1:0] idx_q;
  logic [CSR_IDX_W-1:0] quo;
  logic [PROD_W-1:0] quo_prod;
  logic [VADDR_BITS-1:0] vbase;

  logic s_we, s_re, v_we, v_re;
  logic [SADDR_BITS-1:0] s_waddr, s_raddr;
  logic [VADDR_BITS-1:0] v_waddr, v_raddr;
  logic [31:0] s_wdata, v_wdata, s_rdata, v_rdata, s_new;

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ACTIVE_THREADS) ? {25'd0, active_threads} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_threads <= ACTIVE_THREADS_RESET;
    end else if (psel && penable && pwrite && paddr == CFG_ACTIVE_THREADS) begin
      active_threads <= pwdata[6:0];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign op_in = op_t'(req_type);
  assign warp_ok = (32'(warp_slot) < WARPS);
  assign item_go = writes_back && warp_ok && (req_type <= OP_SETRPC);
  assign out_free = !out_valid || !out_stall;
  assign saddr_in = SADDR_BITS'({WARP_BITS'(warp_slot), CSR_ADDR_BITS'(csr_index)});
  assign rpc_addr = SADDR_BITS'({WARP_BITS'(warp_slot), CSR_ADDR_BITS'(RPC_CSR)});
  assign lane_inc = lane + 1'b1;
  assign quo_prod = PROD_W'(idx_q) * PROD_W'(RECIP);

  always_comb begin
    case (op_q)
      OP_RW, OP_RWI: s_new = s1_q;
      OP_RS, OP_RSI: s_new = s_rdata | s1_q;
      OP_RC, OP_RCI: s_new = s_rdata & ~s1_q;
      default:       s_new = s_rdata;
    endcase
  end

  always_comb begin
    state_next = state;
    clr_cnt_next = clr_cnt;
    lane_next = lane;
    s_we = 1'b0;
    s_waddr = saddr_q;
    s_wdata = s_new;
    s_re = 1'b0;
    s_raddr = saddr_in;
    v_we = 1'b0;
    v_waddr = vbase + VADDR_BITS'(lane);
    v_wdata = v_rdata | s1_q;
    v_re = 1'b0;
    v_raddr = vbase + VADDR_BITS'(lane_inc);
    out_load = 1'b0;
    out_value = s_rdata;
    out_lane = '0;
    out_last = 1'b1;
    case (state)
      ST_CLEAR: begin
        s_we = 1'b1;
        s_waddr = SADDR_BITS'(clr_cnt);
        s_wdata = '0;
        v_we = (32'(clr_cnt) < VDEPTH);
        v_waddr = VADDR_BITS'(clr_cnt);
        v_wdata = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == CLR_BITS'(CDEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && item_go) begin
          case (op_in)
            OP_RW, OP_RS, OP_RC, OP_RWI, OP_RSI, OP_RCI: begin
              s_re = 1'b1;
              state_next = ST_SMOD;
            end
            OP_VRS: begin
              state_next = ST_VMOD;
            end
            OP_VSETVLI: begin
              state_next = ST_SOLE;
            end
            OP_SETRPC: begin
              s_we = 1'b1;
              s_waddr = rpc_addr;
              s_wdata = source_one + source_two;
              state_next = ST_SOLE;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_SMOD: begin
        if (out_free) begin
          out_load = 1'b1;
          s_we = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SOLE: begin
        out_value = res_q;
        if (out_free) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_VMOD: begin
        state_next = ST_VBASE;
      end
      ST_VBASE: begin
        state_next = ST_VREAD;
      end
      ST_VREAD: begin
        v_re = 1'b1;
        v_raddr = vbase;
        lane_next = '0;
        state_next = ST_VLANE;
      end
      ST_VLANE: begin
        out_value = v_rdata;
        out_lane = lane;
        out_last = (lane == LANE_BITS'(THREADS - 1));
        if (out_free) begin
          out_load = 1'b1;
          v_we = 1'b1;
          if (out_last) begin
            state_next = ST_IDLE;
          end else begin
            v_re = 1'b1;
            lane_next = lane_inc;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      lane <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_cnt_next;
      lane <= lane_next;
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q <= op_in;
      warp_q <= warp_slot;
      s1_q <= source_one;
      saddr_q <= saddr_in;
      idx_q <= csr_index;
      res_q <= (op_in == OP_VSETVLI) ? 32'(active_threads) : 32'd0;
    end
    if (state == ST_VMOD) begin
      quo <= quo_prod[CSR_IDX_W+RECIP_SHIFT-1:RECIP_SHIFT];
    end
    if (state == ST_VBASE) begin
      vbase <= VADDR_BITS'(32'(warp_q) * ENTRY_SPAN + 32'(idx_q) * THREADS
                           - 32'(quo) * ENTRY_SPAN);
    end
    if (out_load) begin
      out_warp <= warp_q;
      lane_index <= 6'(out_lane);
      read_value <= out_value;
      is_last <= out_last;
    end
  end

  wcsr_ram #(
    .WIDTH(32),
    .DEPTH(SDEPTH)
  ) u_scalar_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .re   (s_re),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  wcsr_ram #(
    .WIDTH(32),
    .DEPTH(VDEPTH)
  ) u_vector_ram (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata(v_wdata),
    .re   (v_re),
    .raddr(v_raddr),
    .rdata(v_rdata)
  );

  a_scalar_read_then_modify: assert property (@(posedge clk) disable iff (rst)
    s_re |=> state == ST_SMOD)
    else $error("scalar read not followed by write-back state");

  a_lane_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_VLANE |-> 32'(lane) < THREADS)
    else $error("vector lane out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ST_SMOD || state == ST_SOLE || state == ST_VLANE))
    else $error("result loaded outside a result state");

  a_vector_write_context: assert property (@(posedge clk) disable iff (rst)
    v_we |-> (state == ST_CLEAR || (state == ST_VLANE && out_load)))
    else $error("vector store written without a result");

endmodule

// ===== test/wcsr_result_checker.sv =====
`timescale 1ns / 100ps

module wcsr_result_checker #(
  parameter int WARPS = 8,
  parameter int THREADS = 32,
  parameter int CSR_ADDR_BITS = 12,
  parameter int VECTOR_CSR_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic [2:0]  warp_slot,
  input  logic [11:0] csr_index,
  input  logic [31:0] source_one,
  input  logic [31:0] source_two,
  input  logic        writes_back,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_warp,
  input  logic [5:0]  lane_index,
  input  logic [31:0] read_value,
  input  logic        is_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          results_due
);

  import wcsr_pkg::*;

  localparam int CSR_SPAN = 1 << CSR_ADDR_BITS;

  typedef struct packed {
    logic [2:0]  warp;
    logic [5:0]  lane;
    logic [31:0] value;
    logic        last;
  } csr_result_t;

  logic [31:0] scalar_csrs [WARPS*CSR_SPAN];
  logic [31:0] vector_csrs [WARPS*VECTOR_CSR_ENTRIES*THREADS];
  logic [6:0]  thread_count;
  csr_result_t pending_reads[$];
  int          mismatches;

  assign mismatch_count = mismatches;
  assign results_due = pending_reads.size();

  task automatic model_csr_item(input logic [3:0] op, input logic [2:0] warp,
                                input logic [11:0] csr_num, input logic [31:0] s1,
                                input logic [31:0] s2, input logic wb);
    int slot;
    int vbase;
    logic [31:0] old;
    logic [CSR_ADDR_BITS-1:0] rpc_addr;
    if (!wb || warp >= WARPS) return;
    slot = warp * CSR_SPAN + csr_num[CSR_ADDR_BITS-1:0];
    case (op)
      OP_RW, OP_RWI: begin
        old = scalar_csrs[slot];
        scalar_csrs[slot] = s1;
      end
      OP_RS, OP_RSI: begin
        old = scalar_csrs[slot];
        scalar_csrs[slot] = old | s1;
      end
      OP_RC, OP_RCI: begin
        old = scalar_csrs[slot];
        scalar_csrs[slot] = old & ~s1;
      end
      OP_VRS: begin
        vbase = (warp * VECTOR_CSR_ENTRIES + csr_num % VECTOR_CSR_ENTRIES) * THREADS;
        for (int lane = 0; lane < THREADS; lane++) begin
          pending_reads.push_back('{warp, lane[5:0], vector_csrs[vbase + lane],
                                    lane == THREADS - 1});
          vector_csrs[vbase + lane] = vector_csrs[vbase + lane] | s1;
        end
        return;
      end
      OP_VSETVLI: begin
        old = {25'd0, thread_count};
      end
      OP_SETRPC: begin
        rpc_addr = RPC_CSR[CSR_ADDR_BITS-1:0];
        scalar_csrs[warp * CSR_SPAN + rpc_addr] = s1 + s2;
        old = '0;
      end
      default: return;
    endcase
    pending_reads.push_back('{warp, 6'd0, old, 1'b1});
  endtask

  always @(posedge clk) begin
    csr_result_t want;
    csr_result_t got;
    if (rst) begin
      foreach (scalar_csrs[i]) scalar_csrs[i] = '0;
      foreach (vector_csrs[i]) vector_csrs[i] = '0;
      thread_count = ACTIVE_THREADS_RESET;
      pending_reads.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CFG_ACTIVE_THREADS) begin
        thread_count = pwdata[6:0];
      end
      if (in_valid && !in_stall) begin
        model_csr_item(req_type, warp_slot, csr_index, source_one, source_two,
                       writes_back);
      end
      if (out_valid && !out_stall) begin
        got = '{out_warp, lane_index, read_value, is_last};
        if (pending_reads.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result warp %0d lane %0d value %h last %0b",
                     $realtime, got.warp, got.lane, got.value, got.last);
          end
          mismatches++;
        end else begin
          want = pending_reads.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: expected warp %0d lane %0d value %h last %0b, got warp %0d lane %0d value %h last %0b",
                       $realtime, want.warp, want.lane, want.value, want.last,
                       got.warp, got.lane, got.value, got.last);
            end
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  import wcsr_pkg::*;

  localparam logic [3:0] OP_BAD_LOW = 4'd9;
  localparam logic [3:0] OP_BAD_HIGH = 4'd15;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  req_type;
  logic [2:0]  warp_slot;
  logic [11:0] csr_index;
  logic [31:0] source_one;
  logic [31:0] source_two;
  logic        writes_back;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_warp;
  logic [5:0]  lane_index;
  logic [31:0] read_value;
  logic        is_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          results_due;
  bit          sender_idles;
  bit          receiver_idles;
  bit          long_hold;

  warp_csr_exec_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .warp_slot  (warp_slot),
    .csr_index  (csr_index),
    .source_one (source_one),
    .source_two (source_two),
    .writes_back(writes_back),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_warp   (out_warp),
    .lane_index (lane_index),
    .read_value (read_value),
    .is_last    (is_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  wcsr_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .warp_slot     (warp_slot),
    .csr_index     (csr_index),
    .source_one    (source_one),
    .source_two    (source_two),
    .writes_back   (writes_back),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_warp      (out_warp),
    .lane_index    (lane_index),
    .read_value    (read_value),
    .is_last       (is_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver stalls in short random bursts, or once for a long stretch so that
  // the block backs up and stalls its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic issue(input logic [3:0] op, input logic [2:0] warp,
                       input logic [11:0] csr_num, input logic [31:0] s1,
                       input logic [31:0] s2, input logic wb);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_type <= op;
    warp_slot <= warp;
    csr_index <= csr_num;
    source_one <= s1;
    source_two <= s2;
    writes_back <= wb;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_csr_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [3:0] op;
    logic [11:0] csr_num;
    logic [31:0] s1;
    logic wb;
    pick = $urandom_range(0, 99);
    wb = ($urandom_range(0, 9) != 0);
    if (pick < 9) op = OP_VRS;
    else if (pick < 16) op = OP_VSETVLI;
    else if (pick < 26) op = OP_SETRPC;
    else if (pick < 31) op = 4'($urandom_range(OP_BAD_LOW, OP_BAD_HIGH));
    else op = 4'($urandom_range(OP_RW, OP_RCI));
    case ($urandom_range(0, 9))
      0: csr_num = RPC_CSR;
      1: csr_num = 12'hfff;
      2, 3: csr_num = 12'h300 + 12'($urandom_range(0, 3));
      4, 5, 6: csr_num = 12'($urandom_range(0, 15));
      default: csr_num = 12'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: s1 = 32'd1 << $urandom_range(0, 31);
      1: s1 = $urandom_range(0, 31);
      2: s1 = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
      default: s1 = $urandom;
    endcase
    issue(op, 3'($urandom_range(0, 7)), csr_num, s1, $urandom, wb);
  endtask

  task automatic random_items(input int count);
    repeat (count) random_item();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = OP_RW;
    warp_slot = '0;
    csr_index = '0;
    source_one = '0;
    source_two = '0;
    writes_back = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = CFG_ACTIVE_THREADS;
    pwdata = '0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    long_hold = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_csr_reg(CFG_ACTIVE_THREADS, 32'd64);
    issue(OP_VSETVLI, 3'd0, 12'h000, 32'h0, 32'h0, 1'b1);
    issue(OP_RW, 3'd0, 12'h000, 32'hffff_ffff, 32'h0, 1'b1);
    issue(OP_RS, 3'd0, 12'h000, 32'h0, 32'hffff_ffff, 1'b1);
    issue(OP_RC, 3'd0, 12'h000, 32'h0f0f_0f0f, 32'h0, 1'b1);
    issue(OP_RWI, 3'd7, 12'hfff, 32'h0000_001f, 32'h0, 1'b1);
    issue(OP_RSI, 3'd7, 12'hfff, 32'h0, 32'h0, 1'b1);
    issue(OP_RCI, 3'd7, 12'hfff, 32'h0000_0001, 32'h0, 1'b1);
    issue(OP_SETRPC, 3'd3, 12'h000, 32'hffff_ffff, 32'h0000_0001, 1'b1);
    issue(OP_RS, 3'd3, RPC_CSR, 32'h0, 32'h0, 1'b1);
    issue(OP_SETRPC, 3'd3, 12'hfff, 32'h1234_5678, 32'h8765_4321, 1'b1);
    issue(OP_RW, 3'd3, RPC_CSR, 32'h5555_aaaa, 32'h0, 1'b1);
    issue(OP_VRS, 3'd0, 12'h005, 32'ha5a5_a5a5, 32'h0, 1'b1);
    issue(OP_VRS, 3'd0, 12'h015, 32'h5a5a_5a5a, 32'h0, 1'b1);
    issue(OP_VRS, 3'd7, 12'hfff, 32'hffff_ffff, 32'h0, 1'b1);
    issue(OP_VRS, 3'd7, 12'h00f, 32'h0, 32'h0, 1'b1);
    issue(OP_RW, 3'd0, 12'h000, 32'h1111_1111, 32'h0, 1'b0);
    issue(OP_VRS, 3'd0, 12'h005, 32'hffff_ffff, 32'h0, 1'b0);
    issue(OP_BAD_LOW, 3'd0, 12'h000, 32'hffff_ffff, 32'h0, 1'b1);
    issue(OP_BAD_HIGH, 3'd7, 12'hfff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    issue(OP_RW, 3'd0, 12'h000, 32'h0, 32'h0, 1'b1);
    issue(OP_RW, 3'd5, RPC_CSR, 32'hdead_beef, 32'h0, 1'b1);
    issue(OP_RS, 3'd5, RPC_CSR, 32'h0, 32'h0, 1'b1);
    drain_and_settle();

    write_csr_reg(CFG_ACTIVE_THREADS, 32'd1);
    issue(OP_VSETVLI, 3'd7, 12'hfff, 32'h0, 32'h0, 1'b1);
    random_items(50);
    drain_and_settle();

    write_csr_reg(CFG_ACTIVE_THREADS, $urandom_range(1, 64));
    long_hold = 1'b1;
    sender_idles = 1'b0;
    repeat (8) begin
      issue(OP_VRS, 3'($urandom_range(0, 7)), 12'($urandom), $urandom, $urandom, 1'b1);
    end
    sender_idles = 1'b1;
    random_items(55);
    drain_and_settle();

    write_csr_reg(CFG_ACTIVE_THREADS, {25'd0, ACTIVE_THREADS_RESET});
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    issue(OP_VSETVLI, 3'd4, 12'h000, 32'h0, 32'h0, 1'b1);
    random_items(35);
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wcsr_pkg.sv
rtl/core/wcsr_ram.sv
rtl/core/warp_csr_exec_unit.sv
test/wcsr_result_checker.sv
test/tb_top.sv
